// ----- design/tlvv_pkg.sv -----
// Package for the TLV record validator: payload structs, status codes,
// queue sizing and the small modulo-13 reduction helper.
// No dependencies.
`default_nettype none
package tlvv_pkg;

    // Status codes carried in the result beat.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_BADLEN   = 3'd3;
    localparam logic [2:0] ST_TOOLARGE = 3'd4;
    localparam logic [2:0] ST_TERM     = 3'd5;
    localparam logic [2:0] ST_CHECKSUM = 3'd6;

    // Record types.
    localparam logic [7:0] TYPE_FLAG    = 8'h01;
    localparam logic [7:0] TYPE_INTEGER = 8'h02;
    localparam logic [7:0] TYPE_COMPLEX = 8'h03;

    localparam logic [7:0] TERMINATOR_BYTE = 8'hff;
    localparam logic [7:0] INTEGER_LENGTH  = 8'd4;
    localparam logic [8:0] POS_MAX         = 9'd511;
    localparam logic [8:0] HEADER_BYTES    = 9'd2;

    // Configuration register indexes and reset values.
    localparam logic CFG_INTEGER_LIMIT      = 1'b0;
    localparam logic CFG_COMPLEX_MIN_LENGTH = 1'b1;
    localparam logic [31:0] INTEGER_LIMIT_RESET      = 32'd1000000;
    localparam logic [7:0]  COMPLEX_MIN_LENGTH_RESET = 8'd10;

    // Summary queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] consumed;
        logic [7:0] record_type;
        logic [7:0] record_length;
    } t_result;

    // Everything the back needs to judge one finished buffer.
    typedef struct packed {
        logic [8:0]  byte_count;
        logic [7:0]  rtype;
        logic [7:0]  rlength;
        logic [3:0]  residue;
        logic [31:0] value;
        logic        term_seen;
    } t_summary;

    // Push side of the summary queue.
    typedef struct packed {
        logic     push;
        t_summary data;
    } t_sum_push;

    // Reduce a value below 78 to its residue modulo 13 by compare and subtract.
    function automatic logic [3:0] mod13_small(input logic [6:0] v);
        logic [6:0] r;
        if (v >= 7'd65) begin
            r = v - 7'd65;
        end else if (v >= 7'd52) begin
            r = v - 7'd52;
        end else if (v >= 7'd39) begin
            r = v - 7'd39;
        end else if (v >= 7'd26) begin
            r = v - 7'd26;
        end else if (v >= 7'd13) begin
            r = v - 7'd13;
        end else begin
            r = v;
        end
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/tlv_record_validator.sv -----
// TLV record validator top level: front byte tracker, summary queue and
// judging back end with its output register.
// Depends on tlvv_pkg, tlvv_front, tlvv_queue and tlvv_back.
//
// Usage:
//   Input channel: drive i_item (data_byte, last_byte) and raise push; a beat
//   is taken at each edge with push high and full low. One byte per beat,
//   with last_byte set on the final byte of each buffer.
//   Result channel: while empty is low, o_result holds the oldest result;
//   raising pop takes it. Exactly one result follows each last byte.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 integer limit, 1 complex minimum length) at the clock edge; write
//   only while no buffer is in flight.
// Timing:
//   One byte per cycle sustained while full stays low. The summary of a
//   buffer enters the queue at the edge that takes its last byte and moves
//   on to the output register once the register is free.
//   The front summarizes a buffer in a single per-byte update.
// Stalls and reset:
//   When pop stays low, the output register and the two-entry summary queue
//   fill; full rises only once the queue is full. Synchronous reset clears
//   the record state, empties the queue and restores the register defaults.
`default_nettype none
module tlv_record_validator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire tlvv_pkg::t_item   i_item,
    output logic                   empty,
    input  wire logic              pop,
    output tlvv_pkg::t_result      o_result
);
    import tlvv_pkg::*;

    t_sum_push sum_push;
    t_summary  q_head;
    logic      q_full;
    logic      q_empty;
    logic      head_take;
    logic      in_accept;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    // Byte tracker.
    tlvv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_sum    (sum_push)
    );

    // Summary queue.
    tlvv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sum   (sum_push),
        .i_pop   (head_take),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Judge and output register.
    tlvv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_head_take  (head_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

    // The block holds no result right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // A nonzero consumed count only comes with an ok status.
    a_consumed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.consumed != 9'd0) |-> (o_result.status == ST_OK))
        else $error("consumed count on a failed record");

    // An ok record consumes its header and its full payload.
    a_ok_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_OK)
        |-> (o_result.consumed == HEADER_BYTES + {1'b0, o_result.record_length}))
        else $error("ok record with wrong consumed count");

    // A summary waits in the queue only if the output register is occupied.
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_empty && !head_take) |-> !empty)
        else $error("summary held back while output register is free");

endmodule
`default_nettype wire

// ----- design/tlvv_front.sv -----
// Front of the TLV validator: takes one buffer byte per beat, keeps the
// running record state and hands a summary to the queue on the last byte.
// Depends on tlvv_pkg.
`default_nettype none
module tlvv_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire tlvv_pkg::t_item   i_item,
    output tlvv_pkg::t_sum_push    o_sum
);
    import tlvv_pkg::*;

    logic [8:0]  r_pos,  n_pos;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len,  n_len;
    logic [3:0]  r_res,  n_res;
    logic [31:0] r_acc,  n_acc;
    logic        r_term, n_term;

    logic [8:0]  pay_idx;
    logic        in_payload;
    logic [6:0]  res_sum;
    logic [7:0]  b;

    // Per-byte update of the record state.
    always_comb begin
        b       = i_item.data_byte;
        n_pos   = (r_pos < POS_MAX) ? r_pos + 9'd1 : r_pos;
        n_type  = r_type;
        n_len   = r_len;
        n_res   = r_res;
        n_acc   = r_acc;
        n_term  = r_term;
        pay_idx = r_pos - HEADER_BYTES;
        in_payload = (r_pos >= HEADER_BYTES) && (pay_idx < {1'b0, r_len});
        // 16 is 3 modulo 13, so the high nibble counts three times.
        res_sum = 7'({2'b00, b[7:4], 1'b0}) + 7'({3'b000, b[7:4]})
                + 7'({3'b000, b[3:0]}) + 7'({3'b000, r_res});
        if (r_pos == 9'd0) begin
            n_type = b;
        end else if (r_pos == 9'd1) begin
            n_len = b;
        end else if (in_payload) begin
            if (pay_idx < 9'd4) begin
                n_acc = r_acc | (32'(b) << {pay_idx[1:0], 3'b000});
            end
            if (b == TERMINATOR_BYTE) begin
                n_term = 1'b1;
            end
            n_res = mod13_small(res_sum);
        end
    end

    // The summary carries the state with the last byte applied.
    always_comb begin
        o_sum.push           = i_accept && i_item.last_byte;
        o_sum.data.byte_count = n_pos;
        o_sum.data.rtype     = n_type;
        o_sum.data.rlength   = n_len;
        o_sum.data.residue   = n_res;
        o_sum.data.value     = n_acc;
        o_sum.data.term_seen = n_term;
    end

    // State registers; the last byte clears them for the next buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_pos  <= '0;
            r_type <= '0;
            r_len  <= '0;
            r_res  <= '0;
            r_acc  <= '0;
            r_term <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_type <= n_type;
            r_len  <= n_len;
            r_res  <= n_res;
            r_acc  <= n_acc;
            r_term <= n_term;
        end
    end

endmodule
`default_nettype wire

// ----- design/tlvv_queue.sv -----
// Short queue of buffer summaries between the front and the back.
// Depends on tlvv_pkg for the summary type and the queue depth.
`default_nettype none
module tlvv_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tlvv_pkg::t_sum_push i_sum,
    input  wire logic                i_pop,
    output logic                     o_full,
    output logic                     o_empty,
    output tlvv_pkg::t_summary       o_head
);
    import tlvv_pkg::*;

    t_summary            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_sum.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_sum.data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/tlvv_back.sv -----
// Back of the TLV validator: holds the configuration registers, judges
// the summary at the queue head and keeps the result in an output register.
// Depends on tlvv_pkg.
`default_nettype none
module tlvv_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_head_valid,
    input  wire tlvv_pkg::t_summary i_head,
    output logic                    o_head_take,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output tlvv_pkg::t_result       o_result
);
    import tlvv_pkg::*;

    logic [31:0] r_integer_limit;
    logic [7:0]  r_complex_min_length;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic [8:0]  need;
    logic        short_rec;
    logic [2:0]  st;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integer_limit      <= INTEGER_LIMIT_RESET;
            r_complex_min_length <= COMPLEX_MIN_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INTEGER_LIMIT:      r_integer_limit      <= i_cfg_wdata;
                CFG_COMPLEX_MIN_LENGTH: r_complex_min_length <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Judge the head summary in the order the checks are defined.
    always_comb begin
        need      = HEADER_BYTES + {1'b0, i_head.rlength};
        short_rec = (i_head.byte_count < need);
        if (i_head.byte_count < HEADER_BYTES) begin
            st = ST_SHORT;
        end else if (i_head.rtype == TYPE_FLAG) begin
            if (i_head.rlength == 8'd0)  st = ST_BADLEN;
            else if (short_rec)          st = ST_SHORT;
            else                         st = ST_OK;
        end else if (i_head.rtype == TYPE_INTEGER) begin
            if (i_head.rlength != INTEGER_LENGTH)     st = ST_BADLEN;
            else if (short_rec)                       st = ST_SHORT;
            else if (i_head.value > r_integer_limit)  st = ST_TOOLARGE;
            else                                      st = ST_OK;
        end else if (i_head.rtype == TYPE_COMPLEX) begin
            if (i_head.rlength < r_complex_min_length) st = ST_BADLEN;
            else if (short_rec)                        st = ST_SHORT;
            else if (i_head.term_seen)                 st = ST_TERM;
            else if (i_head.residue != 4'd0)           st = ST_CHECKSUM;
            else                                       st = ST_OK;
        end else begin
            st = ST_UNKNOWN;
        end
        n_out.status        = st;
        n_out.consumed      = (st == ST_OK) ? need : 9'd0;
        n_out.record_type   = i_head.rtype;
        n_out.record_length = i_head.rlength;
    end

    // Output register loads from a valid queue head whenever it is free or being drained.
    assign o_head_take = i_head_valid && (!r_out_valid || i_pop);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_head_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_take) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
